>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMP(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NXT(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, c, r, a, b)
`define ASSERT_NXT(lbl, c, r, a, b)
`endif

`endif

>>> rtl/ppfp_pkg.sv
// ----------------------------------------------------------------------------
// ppfp_pkg
// Types and constants of the point frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ppfp_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;
  localparam logic [7:0] POINT_TYPE  = 8'h01;
  localparam logic [7:0] POINT_LEN   = 8'h08;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef enum logic [6:0] {
    PH_HUNT1   = 7'b0000001,
    PH_HUNT2   = 7'b0000010,
    PH_TYPE    = 7'b0000100,
    PH_LEN     = 7'b0001000,
    PH_SKIP    = 7'b0010000,
    PH_PAYLOAD = 7'b0100000,
    PH_CHECK   = 7'b1000000
  } ppfp_phase_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } ppfp_beat_t;

  typedef struct packed {
    logic               status;
    logic signed [31:0] radius_nm;
    logic signed [31:0] angle_udeg;
  } ppfp_result_t;

endpackage

`default_nettype wire

>>> rtl/ppfp_in_stage.sv
// ----------------------------------------------------------------------------
// ppfp_in_stage
// Input register for received bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module ppfp_in_stage
  import ppfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  input  wire logic       consume,
  output ppfp_beat_t      beat
);

  logic       held;
  logic [7:0] data;

  assign in_ready   = !held || consume;
  assign beat.valid = held;
  assign beat.data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (consume) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= rx_byte;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ppfp_parser.sv
// ----------------------------------------------------------------------------
// ppfp_parser
// Frame state machine: sync hunt, header, skip, payload and check.
// ----------------------------------------------------------------------------
`default_nettype none

module ppfp_parser
  import ppfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ppfp_beat_t  beat,
  input  wire logic        room,
  output logic             consume,
  output logic             res_valid,
  output ppfp_result_t     res
);

  ppfp_phase_t phase, phase_next;
  logic [8:0]  skip_count, skip_count_next, skip_dec;
  logic [63:0] payload_shift, payload_shift_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [2:0]  byte_index, byte_index_next;

  assign consume   = beat.valid && ((phase != PH_CHECK) || room);
  assign res_valid = beat.valid && (phase == PH_CHECK);
  assign skip_dec  = (skip_count != 9'd0) ? skip_count - 9'd1 : skip_count;

  always_comb begin
    phase_next         = phase;
    skip_count_next    = skip_count;
    payload_shift_next = payload_shift;
    running_xor_next   = running_xor;
    byte_index_next    = byte_index;
    res                = '0;
    unique case (phase)
      PH_HUNT2: begin
        phase_next = (beat.data == SYNC_SECOND) ? PH_TYPE : PH_HUNT1;
      end
      PH_TYPE: begin
        running_xor_next = beat.data;
        phase_next       = PH_LEN;
      end
      PH_LEN: begin
        if (running_xor == POINT_TYPE && beat.data == POINT_LEN) begin
          running_xor_next   = running_xor ^ beat.data;
          payload_shift_next = '0;
          byte_index_next    = 3'd0;
          phase_next         = PH_PAYLOAD;
        end else begin
          skip_count_next = {1'b0, beat.data} + 9'd1;
          phase_next      = PH_SKIP;
        end
      end
      PH_SKIP: begin
        skip_count_next = skip_dec;
        if (skip_dec == 9'd0) begin
          phase_next = PH_HUNT1;
        end
      end
      PH_PAYLOAD: begin
        for (int k = 0; k < 8; k++) begin
          if (byte_index == 3'(k)) begin
            payload_shift_next[8*k +: 8] = payload_shift[8*k +: 8] | beat.data;
          end
        end
        running_xor_next = running_xor ^ beat.data;
        if (byte_index == 3'd7) begin
          byte_index_next = 3'd0;
          phase_next      = PH_CHECK;
        end else begin
          byte_index_next = byte_index + 3'd1;
        end
      end
      PH_CHECK: begin
        if (beat.data == running_xor) begin
          res.status     = STATUS_OK;
          res.radius_nm  = payload_shift[31:0];
          res.angle_udeg = payload_shift[63:32];
        end else begin
          res.status = STATUS_BAD;
        end
        phase_next = PH_HUNT1;
      end
      default: begin
        phase_next = (beat.data == SYNC_FIRST) ? PH_HUNT2 : PH_HUNT1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT1;
    end else if (consume) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (consume) begin
      skip_count    <= skip_count_next;
      payload_shift <= payload_shift_next;
      running_xor   <= running_xor_next;
      byte_index    <= byte_index_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ppfp_out_stage.sv
// ----------------------------------------------------------------------------
// ppfp_out_stage
// Result register toward the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ppfp_out_stage
  import ppfp_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          res_valid,
  input  wire ppfp_result_t  res,
  output logic               room,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               status,
  output logic signed [31:0] radius_nm,
  output logic signed [31:0] angle_udeg
);

  logic load;

  assign room = !out_valid || out_ready;
  assign load = res_valid && room;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status     <= res.status;
      radius_nm  <= res.radius_nm;
      angle_udeg <= res.angle_udeg;
    end
  end

endmodule

`default_nettype wire

>>> rtl/polar_point_frame_parser_top.sv
// ----------------------------------------------------------------------------
// polar_point_frame_parser_top
// Framed point-packet parser for a received byte stream.
// ----------------------------------------------------------------------------
// Takes one byte per cycle. A byte is registered, parsed in the following
// cycle and a result, when the check byte of a point frame completes,
// appears in the result register in the cycle after the parser consumes that
// check byte. The only stall comes from the result register: a waiting check
// byte holds the input while an earlier result has not been taken.
`default_nettype none
`include "assert_macros.svh"

module polar_point_frame_parser_top
  import ppfp_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    rx_byte,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               status,
  output logic signed [31:0] radius_nm,
  output logic signed [31:0] angle_udeg
);

  ppfp_beat_t   beat;
  ppfp_result_t res;
  logic         consume;
  logic         res_valid;
  logic         room;

  ppfp_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .consume  (consume),
    .beat     (beat)
  );

  ppfp_parser u_parse (
    .clk       (clk),
    .rst       (rst),
    .beat      (beat),
    .room      (room),
    .consume   (consume),
    .res_valid (res_valid),
    .res       (res)
  );

  ppfp_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .res_valid  (res_valid),
    .res        (res),
    .room       (room),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .radius_nm  (radius_nm),
    .angle_udeg (angle_udeg)
  );

  `ASSERT_IMP(a_bad_zero, clk, rst, out_valid && status == STATUS_BAD, radius_nm == 32'sd0 && angle_udeg == 32'sd0)
  `ASSERT_IMP(a_ready_free, clk, rst, !out_valid, in_ready)
  `ASSERT_IMP(a_res_src, clk, rst, $rose(out_valid), $past(consume && res_valid))
  `ASSERT_NXT(a_beat_hold, clk, rst, beat.valid && !consume, beat.valid)

endmodule

`default_nettype wire

>>> dv/polar_point_frame_parser_top_test.sv
// ----------------------------------------------------------------------------
// polar_point_frame_parser_top_test
// Self-checking bench for the framed point-packet parser.
// ----------------------------------------------------------------------------
// Feeds a byte stream through the valid/ready input and checks every result
// beat against a cycle-free parser model kept in the bench. A short table
// covers extreme payloads, a broken marker and a bad check byte. Random
// traffic follows: mostly well-formed point frames, with unknown frames
// (including a 256-byte skip), noise and cut-off sequences. Both sides
// idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module polar_point_frame_parser_top_test
  import ppfp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT     = 2000;
  localparam int DRAIN_CYCLES       = 16;
  localparam int RANDOM_FRAME_BYTES = 1250;
  localparam int REPORT_MAX         = 10;
  localparam int DIR_ROWS           = 28;

  localparam ppfp_result_t NO_POINT   = '0;
  localparam ppfp_result_t BAD_POINT  = '{STATUS_BAD, 32'sd0, 32'sd0};
  localparam ppfp_result_t EDGE_POINT = '{STATUS_OK, 32'sh80000000, 32'sh7FFFFFFF};

  typedef struct packed {
    logic [7:0]   data;
    logic         typed;
    ppfp_result_t want;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         rx_byte = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               status;
  logic signed [31:0] radius_nm;
  logic signed [31:0] angle_udeg;

  polar_point_frame_parser_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .radius_nm  (radius_nm),
    .angle_udeg (angle_udeg)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // good frame with extreme radius/angle, broken marker, bad check byte
  dir_row_t directed [DIR_ROWS] = '{
    '{8'hAA, 1'b0, NO_POINT}, '{8'h55, 1'b0, NO_POINT},
    '{8'h01, 1'b0, NO_POINT}, '{8'h08, 1'b0, NO_POINT},
    '{8'h00, 1'b0, NO_POINT}, '{8'h00, 1'b0, NO_POINT},
    '{8'h00, 1'b0, NO_POINT}, '{8'h80, 1'b0, NO_POINT},
    '{8'hFF, 1'b0, NO_POINT}, '{8'hFF, 1'b0, NO_POINT},
    '{8'hFF, 1'b0, NO_POINT}, '{8'h7F, 1'b0, NO_POINT},
    '{8'h09, 1'b1, EDGE_POINT},
    '{8'hAA, 1'b0, NO_POINT}, '{8'h00, 1'b0, NO_POINT},
    '{8'hAA, 1'b0, NO_POINT}, '{8'h55, 1'b0, NO_POINT},
    '{8'h01, 1'b0, NO_POINT}, '{8'h08, 1'b0, NO_POINT},
    '{8'h12, 1'b0, NO_POINT}, '{8'h34, 1'b0, NO_POINT},
    '{8'h56, 1'b0, NO_POINT}, '{8'h78, 1'b0, NO_POINT},
    '{8'h9A, 1'b0, NO_POINT}, '{8'hBC, 1'b0, NO_POINT},
    '{8'hDE, 1'b0, NO_POINT}, '{8'hF0, 1'b0, NO_POINT},
    '{8'h00, 1'b1, BAD_POINT}
  };

  // parser model state
  ppfp_phase_t prs_phase = PH_HUNT1;
  logic [8:0]  skip_left = '0;
  logic [63:0] payload_bits = '0;
  logic [7:0]  frame_xor = '0;
  logic [2:0]  payload_idx = '0;

  ppfp_result_t expected_points[$];

  int  mismatches = 0;
  int  points_checked = 0;
  int  ok_frames = 0;
  int  bad_frames = 0;
  int  skipped_frames = 0;
  int  longest_skip = 0;
  int  frame_bytes = 0;
  int  sent_bytes = 0;
  bit  in_quiet = 1'b0;
  bit  out_quiet = 1'b0;
  int  idle_cycles = 0;

  function automatic void parse_byte(input logic [7:0] b, output bit got,
                                     output ppfp_result_t res);
    got = 1'b0;
    res = NO_POINT;
    case (prs_phase)
      PH_HUNT2: prs_phase = (b == SYNC_SECOND) ? PH_TYPE : PH_HUNT1;
      PH_TYPE: begin
        frame_xor = b;
        prs_phase = PH_LEN;
      end
      PH_LEN: begin
        if (frame_xor == POINT_TYPE && b == POINT_LEN) begin
          frame_xor = frame_xor ^ b;
          payload_bits = '0;
          payload_idx = '0;
          prs_phase = PH_PAYLOAD;
        end else begin
          skip_left = {1'b0, b} + 9'd1;
          prs_phase = PH_SKIP;
          skipped_frames++;
          if (int'(skip_left) > longest_skip) longest_skip = int'(skip_left);
        end
      end
      PH_SKIP: begin
        if (skip_left != '0) skip_left = skip_left - 9'd1;
        if (skip_left == '0) prs_phase = PH_HUNT1;
      end
      PH_PAYLOAD: begin
        payload_bits[8*payload_idx +: 8] = b;
        frame_xor = frame_xor ^ b;
        if (payload_idx == 3'd7) begin
          payload_idx = '0;
          prs_phase = PH_CHECK;
        end else begin
          payload_idx = payload_idx + 3'd1;
        end
      end
      PH_CHECK: begin
        got = 1'b1;
        if (b == frame_xor) begin
          res = '{STATUS_OK, payload_bits[31:0], payload_bits[63:32]};
          ok_frames++;
        end else begin
          res = BAD_POINT;
          bad_frames++;
        end
        prs_phase = PH_HUNT1;
      end
      default: prs_phase = (b == SYNC_FIRST) ? PH_HUNT2 : PH_HUNT1;
    endcase
  endfunction

  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit typed, input ppfp_result_t want);
    int           gap;
    bit           got;
    ppfp_result_t res;
    gap = pick_gap(in_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    sent_bytes++;
    if (prs_phase != PH_SKIP && (prs_phase != PH_HUNT1 || b == SYNC_FIRST)) frame_bytes++;
    parse_byte(b, got, res);
    if (typed) expected_points.push_back(want);
    else if (got) expected_points.push_back(res);
  endtask

  task automatic check_point();
    ppfp_result_t exp_pt;
    points_checked++;
    if (expected_points.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("%0t: result beat with nothing pending: status %b radius %h angle %h",
                 $realtime, status, radius_nm, angle_udeg);
      return;
    end
    exp_pt = expected_points.pop_front();
    if (status !== exp_pt.status || radius_nm !== exp_pt.radius_nm ||
        angle_udeg !== exp_pt.angle_udeg) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("%0t: point %0d: status exp %b got %b, radius exp %h got %h, angle exp %h got %h",
                 $realtime, points_checked, exp_pt.status, status, exp_pt.radius_nm,
                 radius_nm, exp_pt.angle_udeg, angle_udeg);
    end
  endtask

  // result side: check beats, random backpressure
  initial begin : result_side
    int stall;
    int cyc;
    stall = 0;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (!rst && out_valid === 1'b1 && out_ready) check_point();
      if (cyc % 200 == 0) out_quiet = ($urandom_range(0, 3) == 0);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        stall = pick_gap(out_quiet);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : byte_side
    logic [7:0] seq[$];
    logic [7:0] b;
    logic [7:0] xr;
    int         seq_no;
    int         r;
    int         n;
    int         len;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      send_byte(directed[i].data, directed[i].typed, directed[i].want);

    seq_no = 0;
    while (sent_bytes < RANDOM_FRAME_BYTES + DIR_ROWS) begin
      seq.delete();
      in_quiet = ($urandom_range(0, 9) < 2);
      if (seq_no == 20 || $urandom_range(0, 39) == 0) begin
        while (expected_points.size() != 0) begin
          in_valid <= 1'b0;
          @(posedge clk);
        end
      end
      r = (seq_no == 0) ? 60 : $urandom_range(0, 99);
      if (r < 60) begin
        seq = '{SYNC_FIRST, SYNC_SECOND, POINT_TYPE, POINT_LEN};
        xr = POINT_TYPE ^ POINT_LEN;
        for (int k = 0; k < 8; k++) begin
          n = $urandom_range(0, 99);
          b = (n < 10) ? 8'h00 : (n < 20) ? 8'hFF : (n < 25) ? SYNC_FIRST : 8'($urandom);
          xr = xr ^ b;
          seq.push_back(b);
        end
        if ($urandom_range(0, 99) >= 85) xr = xr ^ 8'($urandom_range(1, 255));
        seq.push_back(xr);
      end else if (r < 75) begin
        // unknown frame, skipped by length
        if (seq_no == 0) begin
          b = 8'h5A;
          len = 255;
        end else begin
          n = $urandom_range(0, 99);
          len = (n < 70) ? $urandom_range(0, 15) : (n < 90) ? $urandom_range(16, 64) :
                (n < 97) ? $urandom_range(65, 254) : 255;
          if ($urandom_range(0, 2) == 0) begin
            b = POINT_TYPE;
            if (len == int'(POINT_LEN)) len = 9;
          end else begin
            do b = 8'($urandom); while (b == POINT_TYPE);
            if ($urandom_range(0, 2) == 0) len = int'(POINT_LEN);
          end
        end
        seq = '{SYNC_FIRST, SYNC_SECOND, b, 8'(len)};
        for (int k = 0; k <= len; k++) begin
          n = $urandom_range(0, 99);
          seq.push_back((n < 8) ? SYNC_FIRST : (n < 15) ? SYNC_SECOND : 8'($urandom));
        end
      end else if (r < 85) begin
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++)
          seq.push_back(($urandom_range(0, 9) < 3) ? SYNC_FIRST : 8'($urandom));
      end else begin
        n = $urandom_range(0, 2);
        if (n == 0) begin
          do b = 8'($urandom); while (b == SYNC_SECOND);
          seq = '{SYNC_FIRST, b};
        end else if (n == 1) begin
          seq = '{SYNC_FIRST, SYNC_SECOND, POINT_TYPE, POINT_LEN};
          repeat ($urandom_range(0, 7)) seq.push_back(8'($urandom));
        end else begin
          seq = '{SYNC_FIRST, SYNC_FIRST, SYNC_SECOND, POINT_TYPE, POINT_LEN};
        end
      end
      foreach (seq[k]) send_byte(seq[k], 1'b0, NO_POINT);
      seq_no++;
    end

    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d bytes (%0d in frames) in %0d random sequences", sent_bytes,
             frame_bytes, seq_no);
    $display("%0d good frames, %0d bad checks, %0d unknown frames skipped (longest %0d bytes)",
             ok_frames, bad_frames, skipped_frames, longest_skip);
    $display("%0d result beats checked", points_checked);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
+incdir+rtl
rtl/ppfp_pkg.sv
rtl/ppfp_in_stage.sv
rtl/ppfp_parser.sv
rtl/ppfp_out_stage.sv
rtl/polar_point_frame_parser_top.sv
dv/polar_point_frame_parser_top_test.sv
